// ----- sv/ipfrt_pkg.sv -----
`default_nettype none

package ipfrt_pkg;

    localparam int MAX_FRAGS = 64;
    localparam int IDX_W     = $clog2(MAX_FRAGS);
    localparam int CNT_W     = $clog2(MAX_FRAGS + 1);
    localparam int SLOT_W    = 6;

    localparam logic [16:0] SAT17     = 17'h1FFFF;
    localparam logic [17:0] MAX_DGRAM = 18'd65535;
    localparam logic [5:0]  MIN_HDR   = 6'd20;
    localparam logic        KIND_START = 1'b0;

    typedef enum logic [2:0] {
        ST_OK,
        ST_DONE,
        ST_DUP_LAST,
        ST_DUP_OFF,
        ST_HDR,
        ST_OVERLAP,
        ST_FULL,
        ST_MALFORMED
    } status_t;

    typedef struct packed {
        logic        kind;
        logic [15:0] frag_offset;
        logic [15:0] total_len;
        logic [5:0]  header_len;
        logic        more_frags;
    } in_item_t;

    typedef struct packed {
        logic        accepted;
        status_t     status;
        logic [5:0]  slot;
        logic        first_seen;
        logic        last_seen;
        logic        complete;
        logic        oversize;
        logic [16:0] received_bytes;
        logic [16:0] expected_bytes;
    } out_item_t;

    typedef struct packed {
        logic [15:0] offset;
        logic [15:0] payload;
    } entry_t;

endpackage

`default_nettype wire

// ----- sv/ip_fragment_reassembly_tracker_top.sv -----
// Fragment bookkeeping for one IPv4 datagram.
// Input channel frag_valid / frag_stall / frag carries one item per beat:
// a start item clears the entry, a fragment item is checked and, if it
// passes, stored in a table sorted by ascending offset (the last fragment
// is appended at the tail and fixes the expected payload size).
// Output channel result_valid / result_stall / result returns exactly one
// beat per input beat with the verdict, table slot, flags and byte counts.
// Start items and early rejects go straight from the check to the report;
// a last fragment goes straight to the insert, and other fragments search
// the table first and may shift it. The fragment table sits in one memory
// with a single read and a single write port, so the tail-to-head search
// visits one entry at a time and making room for the insert moves one entry
// at a time. frag_stall is high while an item is in work.
// A finished result waits in an output register, so a new item is taken
// while result_valid is held against result_stall; a second result waits
// inside the block until the first one leaves.
// Reset clears the entry: no fragments, no flags, zero counts. The table
// memory itself is not cleared; only entries below the fill count are used.
`default_nettype none

module ip_fragment_reassembly_tracker_top (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 frag_valid,
    output      logic                 frag_stall,
    input  wire ipfrt_pkg::in_item_t  frag,
    output      logic                 result_valid,
    input  wire logic                 result_stall,
    output      ipfrt_pkg::out_item_t result
);

    import ipfrt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_DECIDE,
        S_SHIFT,
        S_INSERT,
        S_REPORT
    } state_t;

    state_t            state_reg;
    in_item_t          item_reg;
    logic [15:0]       pay_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  pred_reg;
    logic              have_pred_reg;
    logic [16:0]       pred_end_reg;
    logic [IDX_W-1:0]  pos_reg;
    logic              acc_reg;
    status_t           status_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [5:0]        hdr_reg;
    logic [16:0]       recv_reg;
    logic [16:0]       exp_reg;
    logic              first_reg;
    logic              last_reg;
    logic              done_reg;
    logic              out_valid_reg;
    out_item_t         out_reg;

    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    entry_t            wr_entry;
    logic [IDX_W-1:0]  rd_addr;
    logic [31:0]       rd_data;
    entry_t            rd_entry;

    logic [IDX_W-1:0]  count_last;
    logic              full;
    logic              malformed;
    logic [IDX_W-1:0]  insert_pos;
    logic [17:0]       recv_sum;
    logic [16:0]       recv_next;
    logic [16:0]       exp_next;
    logic              first_next;
    logic              last_next;
    logic              done_next;
    logic [17:0]       size_sum;

    ipfrt_ram #(
        .DEPTH (MAX_FRAGS),
        .WIDTH (32)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_entry   = entry_t'(rd_data);
    assign count_last = IDX_W'(count_reg - CNT_W'(1));
    assign full       = (count_reg == CNT_W'(MAX_FRAGS));
    assign malformed  = (item_reg.header_len < MIN_HDR) ||
                        (item_reg.total_len < {10'd0, item_reg.header_len}) ||
                        (item_reg.frag_offset[2:0] != 3'd0);
    assign insert_pos = have_pred_reg ? IDX_W'(pred_reg + IDX_W'(1)) : '0;

    assign recv_sum   = {1'b0, recv_reg} + {2'b00, pay_reg};
    assign recv_next  = (recv_sum > {1'b0, SAT17}) ? SAT17 : recv_sum[16:0];
    assign exp_next   = item_reg.more_frags ? exp_reg
                        : ({1'b0, item_reg.frag_offset} + {1'b0, pay_reg});
    assign first_next = first_reg | (item_reg.more_frags && (item_reg.frag_offset == 16'd0));
    assign last_next  = last_reg | !item_reg.more_frags;
    assign done_next  = done_reg | (first_next && last_next && (recv_next == exp_next));
    assign size_sum   = {12'd0, hdr_reg} + {1'b0, exp_reg};

    always_comb
    begin
        rd_addr  = ((state_reg == S_SCAN) || (state_reg == S_SHIFT))
                   ? IDX_W'(idx_reg - IDX_W'(1)) : count_last;
        wr_en    = 1'b0;
        wr_addr  = pos_reg;
        wr_entry = '{offset: item_reg.frag_offset, payload: pay_reg};
        unique case (state_reg)
            S_SHIFT:
            begin
                wr_en    = 1'b1;
                wr_addr  = IDX_W'(idx_reg + IDX_W'(1));
                wr_entry = rd_entry;
            end
            S_INSERT:
            begin
                wr_en = 1'b1;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            item_reg      <= '0;
            pay_reg       <= '0;
            idx_reg       <= '0;
            pred_reg      <= '0;
            have_pred_reg <= 1'b0;
            pred_end_reg  <= '0;
            pos_reg       <= '0;
            acc_reg       <= 1'b0;
            status_reg    <= ST_OK;
            count_reg     <= '0;
            hdr_reg       <= '0;
            recv_reg      <= '0;
            exp_reg       <= '0;
            first_reg     <= 1'b0;
            last_reg      <= 1'b0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            if (out_valid_reg && !result_stall && (state_reg != S_REPORT))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (frag_valid)
                    begin
                        item_reg  <= frag;
                        pay_reg   <= frag.total_len - {10'd0, frag.header_len};
                        state_reg <= S_CHECK;
                    end
                end

                S_CHECK:
                begin
                    acc_reg <= 1'b0;
                    priority if (item_reg.kind == KIND_START)
                    begin
                        count_reg  <= '0;
                        hdr_reg    <= '0;
                        recv_reg   <= '0;
                        exp_reg    <= '0;
                        first_reg  <= 1'b0;
                        last_reg   <= 1'b0;
                        done_reg   <= 1'b0;
                        status_reg <= ST_OK;
                        state_reg  <= S_REPORT;
                    end
                    else if (done_reg)
                    begin
                        status_reg <= ST_DONE;
                        state_reg  <= S_REPORT;
                    end
                    else if (malformed)
                    begin
                        status_reg <= ST_MALFORMED;
                        state_reg  <= S_REPORT;
                    end
                    else if (!item_reg.more_frags)
                    begin
                        if (last_reg)
                        begin
                            status_reg <= ST_DUP_LAST;
                            state_reg  <= S_REPORT;
                        end
                        else if (full)
                        begin
                            status_reg <= ST_FULL;
                            state_reg  <= S_REPORT;
                        end
                        else
                        begin
                            pos_reg   <= IDX_W'(count_reg);
                            state_reg <= S_INSERT;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        have_pred_reg <= 1'b0;
                        state_reg     <= S_DECIDE;
                    end
                    else
                    begin
                        idx_reg   <= count_last;
                        state_reg <= S_SCAN;
                    end
                end

                S_SCAN:
                begin
                    priority if (rd_entry.offset == item_reg.frag_offset)
                    begin
                        status_reg <= ST_DUP_OFF;
                        state_reg  <= S_REPORT;
                    end
                    else if (rd_entry.offset < item_reg.frag_offset)
                    begin
                        have_pred_reg <= 1'b1;
                        pred_reg      <= idx_reg;
                        pred_end_reg  <= {1'b0, rd_entry.offset} + {1'b0, rd_entry.payload};
                        state_reg     <= S_DECIDE;
                    end
                    else if (idx_reg == '0)
                    begin
                        have_pred_reg <= 1'b0;
                        state_reg     <= S_DECIDE;
                    end
                    else
                    begin
                        idx_reg <= IDX_W'(idx_reg - IDX_W'(1));
                    end
                end

                S_DECIDE:
                begin
                    priority if ((hdr_reg != '0) && (hdr_reg != item_reg.header_len))
                    begin
                        status_reg <= ST_HDR;
                        state_reg  <= S_REPORT;
                    end
                    else
                    begin
                        hdr_reg <= item_reg.header_len;
                        priority if (have_pred_reg &&
                                     (pred_end_reg > {1'b0, item_reg.frag_offset}))
                        begin
                            status_reg <= ST_OVERLAP;
                            state_reg  <= S_REPORT;
                        end
                        else if (full)
                        begin
                            status_reg <= ST_FULL;
                            state_reg  <= S_REPORT;
                        end
                        else if (CNT_W'(insert_pos) == count_reg)
                        begin
                            pos_reg   <= insert_pos;
                            state_reg <= S_INSERT;
                        end
                        else
                        begin
                            pos_reg   <= insert_pos;
                            idx_reg   <= count_last;
                            state_reg <= S_SHIFT;
                        end
                    end
                end

                S_SHIFT:
                begin
                    if (idx_reg == pos_reg)
                    begin
                        state_reg <= S_INSERT;
                    end
                    else
                    begin
                        idx_reg <= IDX_W'(idx_reg - IDX_W'(1));
                    end
                end

                S_INSERT:
                begin
                    count_reg  <= CNT_W'(count_reg + CNT_W'(1));
                    recv_reg   <= recv_next;
                    exp_reg    <= exp_next;
                    first_reg  <= first_next;
                    last_reg   <= last_next;
                    done_reg   <= done_next;
                    acc_reg    <= 1'b1;
                    status_reg <= ST_OK;
                    state_reg  <= S_REPORT;
                end

                S_REPORT:
                begin
                    if (!out_valid_reg || !result_stall)
                    begin
                        out_reg.accepted       <= acc_reg;
                        out_reg.status         <= status_reg;
                        out_reg.slot           <= acc_reg ? SLOT_W'(pos_reg) : '0;
                        out_reg.first_seen     <= first_reg;
                        out_reg.last_seen      <= last_reg;
                        out_reg.complete       <= done_reg;
                        out_reg.oversize       <= (size_sum > MAX_DGRAM);
                        out_reg.received_bytes <= recv_reg;
                        out_reg.expected_bytes <= exp_reg;
                        out_valid_reg          <= 1'b1;
                        state_reg              <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign frag_stall   = (state_reg != S_IDLE);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

`default_nettype wire

// ----- sv/ipfrt_ram.sv -----
`default_nettype none

module ipfrt_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output      logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ----- sv/ipfrt_checker.sv -----
`default_nettype none

module ipfrt_checker (
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 frag_valid,
    input wire logic                 frag_stall,
    input wire logic                 result_valid,
    input wire logic                 result_stall,
    input wire ipfrt_pkg::out_item_t result
);

    import ipfrt_pkg::*;

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result beat changed while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        frag_valid && !frag_stall |=> frag_stall)
        else $error("input taken again while an item is in work");

    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        frag_valid && !frag_stall |=> !$rose(result_valid))
        else $error("result appeared one cycle after an input beat");

    a_complete_counts: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.complete |->
            result.first_seen && result.last_seen &&
            (result.received_bytes == result.expected_bytes))
        else $error("complete without both ends or with unequal counts");

    a_no_last_no_size: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last_seen |-> result.expected_bytes == '0)
        else $error("expected size set before the last fragment");

endmodule

bind ip_fragment_reassembly_tracker_top ipfrt_checker u_ipfrt_checker (.*);

`default_nettype wire

// ----- sim/tb_ip_fragment_reassembly_tracker_top.sv -----
`default_nettype none

module tb_ip_fragment_reassembly_tracker_top;

    timeunit 1ns;
    timeprecision 1ps;

    import ipfrt_pkg::*;

    localparam int RANDOM_ITEMS = 1800;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int TAIL_CYCLES  = 300;

    typedef struct {
        in_item_t beat;
        bit       drain;
    } pending_t;

    logic      clk;
    logic      rst_n;
    logic      frag_valid = 1'b0;
    logic      frag_stall;
    in_item_t  frag = '0;
    logic      result_valid;
    logic      result_stall = 1'b0;
    out_item_t result;

    ip_fragment_reassembly_tracker_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .frag_valid   (frag_valid),
        .frag_stall   (frag_stall),
        .frag         (frag),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // Shadow copy of the datagram entry.
    int        tbl_off [MAX_FRAGS];
    int        tbl_pay [MAX_FRAGS];
    int        frag_cnt;
    int        hdr_seen;
    int        rx_bytes;
    int        exp_bytes;
    bit        have_first;
    bit        have_last;
    bit        is_done;

    pending_t  pend [$];
    out_item_t verdict_q [$];
    int        queued;
    int        errors;
    int        results_seen;
    int        cycle_cnt;

    pending_t  tx_cur;
    bit        tx_busy;
    bit        tx_calm;
    bit        frag_taken;
    int        tx_gap;

    bit        rx_calm;
    bit        hold_done;
    int        hold_left;
    int        rx_gap;

    function automatic void clear_entry();
        frag_cnt   = 0;
        hdr_seen   = 0;
        rx_bytes   = 0;
        exp_bytes  = 0;
        have_first = 1'b0;
        have_last  = 1'b0;
        is_done    = 1'b0;
    endfunction

    function automatic void count_payload(int pay);
        rx_bytes = rx_bytes + pay;
        if (rx_bytes > 131071)
            rx_bytes = 131071;
        if (have_first && have_last && rx_bytes == exp_bytes)
            is_done = 1'b1;
    endfunction

    function automatic out_item_t verdict(bit acc, status_t st, int slot);
        out_item_t r;
        r.accepted       = acc;
        r.status         = st;
        r.slot           = slot[5:0];
        r.first_seen     = have_first;
        r.last_seen      = have_last;
        r.complete       = is_done;
        r.oversize       = (hdr_seen + exp_bytes > 65535);
        r.received_bytes = rx_bytes[16:0];
        r.expected_bytes = exp_bytes[16:0];
        return r;
    endfunction

    function automatic out_item_t track_fragment(in_item_t it);
        int off;
        int hlen;
        int pay;
        int pos;
        int pred;
        int k;
        bit found;
        off   = it.frag_offset;
        hlen  = it.header_len;
        found = 1'b0;
        pred  = 0;
        if (it.kind == KIND_START)
        begin
            clear_entry();
            return verdict(1'b0, ST_OK, 0);
        end
        if (is_done)
            return verdict(1'b0, ST_DONE, 0);
        if (hlen < MIN_HDR || int'(it.total_len) < hlen || it.frag_offset[2:0] != 3'd0)
            return verdict(1'b0, ST_MALFORMED, 0);
        pay = int'(it.total_len) - hlen;

        if (!it.more_frags)
        begin
            if (have_last)
                return verdict(1'b0, ST_DUP_LAST, 0);
            if (frag_cnt >= MAX_FRAGS)
                return verdict(1'b0, ST_FULL, 0);
            pos          = frag_cnt;
            tbl_off[pos] = off;
            tbl_pay[pos] = pay;
            frag_cnt     = frag_cnt + 1;
            have_last    = 1'b1;
            exp_bytes    = (off + pay) & 131071;
            count_payload(pay);
            return verdict(1'b1, ST_OK, pos);
        end

        k = frag_cnt - 1;
        while (k >= 0 && !found)
        begin
            if (tbl_off[k] == off)
                return verdict(1'b0, ST_DUP_OFF, 0);
            if (tbl_off[k] < off)
            begin
                found = 1'b1;
                pred  = k;
            end
            else
                k = k - 1;
        end

        if (hdr_seen != 0 && hdr_seen != hlen)
            return verdict(1'b0, ST_HDR, 0);
        hdr_seen = hlen;

        if (found && tbl_off[pred] + tbl_pay[pred] > off)
            return verdict(1'b0, ST_OVERLAP, 0);
        if (frag_cnt >= MAX_FRAGS)
            return verdict(1'b0, ST_FULL, 0);

        pos = found ? pred + 1 : 0;
        for (k = frag_cnt; k > pos; k--)
        begin
            tbl_off[k] = tbl_off[k - 1];
            tbl_pay[k] = tbl_pay[k - 1];
        end
        tbl_off[pos] = off;
        tbl_pay[pos] = pay;
        frag_cnt     = frag_cnt + 1;
        if (off == 0)
            have_first = 1'b1;
        count_payload(pay);
        return verdict(1'b1, ST_OK, pos);
    endfunction

    function automatic int pick_gap(bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic queue_item(in_item_t it, bit drain);
        pending_t p;
        p.beat  = it;
        p.drain = drain;
        pend    = {pend, p};
        queued++;
    endtask

    task automatic queue_beat(bit kind, int off, int tlen, int hlen, bit mf, bit drain);
        in_item_t it;
        it.kind        = kind;
        it.frag_offset = off[15:0];
        it.total_len   = tlen[15:0];
        it.header_len  = hlen[5:0];
        it.more_frags  = mf;
        queue_item(it, drain);
    endtask

    task automatic queue_noise();
        in_item_t it;
        it.kind        = ($urandom_range(0, 9) != 0);
        it.frag_offset = 16'($urandom_range(0, 65535));
        it.total_len   = 16'($urandom_range(0, 65535));
        it.header_len  = 6'($urandom_range(0, 63));
        it.more_frags  = 1'($urandom_range(0, 1));
        queue_item(it, 1'b0);
    endtask

    // One datagram split into pieces, sent in order or shuffled, with
    // occasional lost pieces and injected faults.
    task automatic queue_datagram(bit drain);
        in_item_t parts [$];
        in_item_t tmp;
        in_item_t bad;
        int n;
        int hlen;
        int off;
        int pay;
        int tlen;
        int mode;
        int j;
        int k;
        hlen = $urandom_range(20, 60);
        mode = $urandom_range(0, 19);
        if (mode == 0)
            n = $urandom_range(60, 70);
        else if (mode < 3)
            n = $urandom_range(1, 3);
        else
            n = $urandom_range(1, 8);
        off = 0;
        for (j = 0; j < n; j++)
        begin
            if (mode == 0)
                pay = 8 * $urandom_range(1, 2);
            else if (mode < 3)
                pay = 8 * $urandom_range(1, 4000);
            else
                pay = 8 * $urandom_range(1, 185);
            if (j == n - 1 && $urandom_range(0, 3) == 0)
                pay = pay - $urandom_range(0, 7);
            tlen           = pay + hlen;
            tmp.kind       = 1'b1;
            tmp.frag_offset = off[15:0];
            tmp.total_len  = tlen[15:0];
            tmp.header_len = hlen[5:0];
            tmp.more_frags = (j != n - 1);
            parts          = {parts, tmp};
            off = off + pay;
        end
        if ($urandom_range(0, 2) != 0)
        begin
            for (j = parts.size() - 1; j > 0; j--)
            begin
                k        = $urandom_range(0, j);
                tmp      = parts[j];
                parts[j] = parts[k];
                parts[k] = tmp;
            end
        end

        queue_beat(1'b0, 0, 0, 0, 1'b0, drain);
        for (j = 0; j < parts.size(); j++)
        begin
            if ($urandom_range(0, 19) != 0)
                queue_item(parts[j], 1'b0);
            if ($urandom_range(0, 11) == 0)
            begin
                bad = parts[j];
                case ($urandom_range(0, 3))
                    0: ;
                    1:
                    begin
                        bad.header_len = (hlen == 60) ? 6'd20 : 6'(hlen + 1);
                        bad.total_len  = bad.total_len + 16'd1;
                    end
                    2: bad.frag_offset = bad.frag_offset | 16'd4;
                    default:
                    begin
                        bad.frag_offset = bad.frag_offset + 16'd8;
                        bad.more_frags  = 1'b1;
                    end
                endcase
                queue_item(bad, 1'b0);
            end
        end
        if ($urandom_range(0, 3) == 0)
            queue_beat(1'b1, off & 16'hFFF8, hlen + 8, hlen, 1'b1, 1'b0);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
        cycle_cnt++;

    initial
    begin : watchdog
        while (cycle_cnt < CYCLE_LIMIT)
            @(posedge clk);
        $display("ip_fragment_reassembly_tracker_top regression: fail");
        $finish;
    end

    always @(negedge clk)
    begin : drive_frags
        if (rst_n)
        begin
            if (frag_taken)
            begin
                frag_taken = 1'b0;
                tx_busy    = 1'b0;
                if ($urandom_range(0, 149) == 0)
                    tx_calm = !tx_calm;
                tx_gap = pick_gap(tx_calm);
            end
            if (!tx_busy)
            begin
                if (tx_gap > 0)
                    tx_gap--;
                else if (pend.size() > 0 && !(pend[0].drain && verdict_q.size() != 0))
                begin
                    tx_cur  = pend[0];
                    pend.delete(0);
                    tx_busy = 1'b1;
                end
            end
            frag_valid <= tx_busy;
            frag       <= tx_cur.beat;
        end
    end

    always @(negedge clk)
    begin : drive_stall
        bit stall_now;
        if (rst_n)
        begin
            stall_now = 1'b0;
            if (!hold_done && results_seen >= 400)
            begin
                hold_done = 1'b1;
                hold_left = 600;
            end
            if ($urandom_range(0, 399) == 0)
                rx_calm = !rx_calm;
            if (hold_left > 0)
            begin
                hold_left--;
                stall_now = 1'b1;
            end
            else if (rx_gap > 0)
            begin
                rx_gap--;
                stall_now = 1'b1;
            end
            else if (!rx_calm && $urandom_range(0, 3) == 0)
            begin
                rx_gap = pick_gap(1'b0);
                if (rx_gap > 0)
                begin
                    rx_gap--;
                    stall_now = 1'b1;
                end
            end
            result_stall <= stall_now;
        end
    end

    always @(posedge clk)
    begin : check_results
        out_item_t want;
        bit        bad;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                results_seen++;
                if (verdict_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result beat %0d: acc=%0d status=%0d slot=%0d",
                                 results_seen, result.accepted, result.status, result.slot);
                end
                else
                begin
                    want = verdict_q[0];
                    verdict_q.delete(0);
                    bad  = (result.accepted !== want.accepted)
                        || (result.status !== want.status)
                        || (result.slot !== want.slot)
                        || (result.first_seen !== want.first_seen)
                        || (result.last_seen !== want.last_seen)
                        || (result.complete !== want.complete)
                        || (result.oversize !== want.oversize)
                        || (result.received_bytes !== want.received_bytes)
                        || (result.expected_bytes !== want.expected_bytes);
                    if (bad)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $display("result beat %0d mismatch", results_seen);
                            $write("  expected acc=%0d st=%0d slot=%0d f=%0d l=%0d",
                                   want.accepted, want.status, want.slot,
                                   want.first_seen, want.last_seen);
                            $display(" c=%0d o=%0d rx=%0d ex=%0d",
                                     want.complete, want.oversize,
                                     want.received_bytes, want.expected_bytes);
                            $write("  actual   acc=%0d st=%0d slot=%0d f=%0d l=%0d",
                                   result.accepted, result.status, result.slot,
                                   result.first_seen, result.last_seen);
                            $display(" c=%0d o=%0d rx=%0d ex=%0d",
                                     result.complete, result.oversize,
                                     result.received_bytes, result.expected_bytes);
                        end
                    end
                end
            end
            if (frag_valid && !frag_stall)
            begin
                verdict_q  = {verdict_q, track_fragment(frag)};
                frag_taken = 1'b1;
            end
        end
    end

    initial
    begin : stimulus
        bit mid_drain;
        clear_entry();
        mid_drain = 1'b0;

        queue_beat(1'b1, 0, 20, 20, 1'b0, 1'b0);
        queue_beat(1'b0, 65535, 65535, 63, 1'b1, 1'b0);
        queue_beat(1'b1, 0, 100, 19, 1'b1, 1'b0);
        queue_beat(1'b1, 0, 59, 60, 1'b1, 1'b0);
        queue_beat(1'b1, 4, 100, 20, 1'b1, 1'b0);
        queue_beat(1'b1, 0, 1500, 20, 1'b1, 1'b0);
        queue_beat(1'b1, 0, 1500, 20, 1'b1, 1'b0);
        queue_beat(1'b1, 2960, 100, 24, 1'b1, 1'b0);
        queue_beat(1'b1, 8, 100, 20, 1'b1, 1'b0);
        queue_beat(1'b1, 2960, 820, 20, 1'b1, 1'b0);
        queue_beat(1'b1, 1480, 1500, 20, 1'b1, 1'b0);
        queue_beat(1'b1, 3760, 60, 20, 1'b0, 1'b0);
        queue_beat(1'b1, 4000, 100, 20, 1'b1, 1'b0);
        queue_beat(1'b1, 3, 5, 0, 1'b1, 1'b0);
        queue_beat(1'b0, 0, 0, 0, 1'b0, 1'b0);
        queue_beat(1'b1, 65528, 65535, 20, 1'b0, 1'b0);
        queue_beat(1'b1, 65528, 65535, 20, 1'b0, 1'b0);
        queue_beat(1'b1, 0, 65535, 63, 1'b1, 1'b0);
        queue_beat(1'b0, 0, 0, 0, 1'b0, 1'b0);
        queue_beat(1'b1, 65528, 65535, 60, 1'b1, 1'b0);
        queue_beat(1'b1, 65520, 65535, 60, 1'b1, 1'b0);
        queue_beat(1'b1, 65512, 65535, 60, 1'b1, 1'b0);
        queue_beat(1'b1, 0, 60, 60, 1'b1, 1'b0);
        queue_beat(1'b0, 0, 0, 0, 1'b0, 1'b0);

        queue_datagram(1'b1);
        while (queued < 24 + RANDOM_ITEMS)
        begin
            if (!mid_drain && queued >= 24 + RANDOM_ITEMS / 2)
            begin
                mid_drain = 1'b1;
                queue_datagram(1'b1);
            end
            else if ($urandom_range(0, 99) < 15)
                queue_noise();
            else
                queue_datagram(1'b0);
        end

        while (pend.size() != 0 || tx_busy || verdict_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        errors = errors + verdict_q.size();

        if (errors == 0)
            $display("ip_fragment_reassembly_tracker_top regression: pass");
        else
            $display("ip_fragment_reassembly_tracker_top regression: fail");
        $finish;
    end

endmodule

`default_nettype wire

// ----- filelist.f -----
sv/ipfrt_pkg.sv
sv/ipfrt_ram.sv
sv/ip_fragment_reassembly_tracker_top.sv
sv/ipfrt_checker.sv
sim/tb_ip_fragment_reassembly_tracker_top.sv
